FILE: hw/rtl/gbcs_pkg.sv
// Package: shared constants and types of the Gray bit-plane coefficient splitter.
`default_nettype none

package gbcs_pkg;

   // default coefficient width
   localparam int COEFF_BITS_DEFAULT = 16;

   // entries in the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // width of the plane index on the result port
   localparam int PLANE_OUT_W = 4;

   // back-end scan phases
   localparam logic [1:0] PHASE_SIG  = 2'd0;
   localparam logic [1:0] PHASE_SIGN = 2'd1;
   localparam logic [1:0] PHASE_REF  = 2'd2;

   // queue status seen by front and back
   typedef struct packed {
      logic not_empty;
      logic full;
   } gbcs_q_status_type;

endpackage

`default_nettype wire

FILE: hw/rtl/gbcs_front.sv
// Front end: accepts coefficients, forms the Gray code and sign, pushes to the queue.
`default_nettype none

module gbcs_front
   import gbcs_pkg::*;
#(
   parameter int COEFF_BITS = COEFF_BITS_DEFAULT
) (
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic [COEFF_BITS-1:0]   req_coefficient,
   input  wire gbcs_q_status_type       q_status,
   output logic                         q_push,
   output logic [COEFF_BITS:0]          q_push_data
);

   logic [COEFF_BITS-1:0] gray;
   logic                  sign;

   always_comb begin
      gray = req_coefficient ^ (req_coefficient >> 1);
      sign = req_coefficient[COEFF_BITS-1];
   end

   // stall only while the queue is full
   assign req_stall   = q_status.full;
   assign q_push      = req_valid && !q_status.full;
   assign q_push_data = {sign, gray};

endmodule

`default_nettype wire

FILE: hw/rtl/gbcs_queue.sv
// Short queue of classified coefficients between front and back.
`default_nettype none

module gbcs_queue
   import gbcs_pkg::*;
#(
   parameter int DATA_W = COEFF_BITS_DEFAULT + 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire logic [DATA_W-1:0] push_data,
   input  wire logic              pop,
   output logic [DATA_W-1:0]      pop_data,
   output gbcs_q_status_type      status
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);

   logic [DATA_W-1:0] entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data         = entry_ff[rd_ptr_ff];
   assign status.not_empty = (count_ff != '0);
   assign status.full      = (count_ff == DEPTH_CNT);

endmodule

`default_nettype wire

FILE: hw/rtl/gbcs_back.sv
// Back end: walks the planes of one coefficient and registers one result per cycle unless rsp_stall holds the output.
`default_nettype none

module gbcs_back
   import gbcs_pkg::*;
#(
   parameter int COEFF_BITS = COEFF_BITS_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire gbcs_q_status_type       q_status,
   input  wire logic [COEFF_BITS:0]     q_pop_data,
   output logic                         q_pop,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic [PLANE_OUT_W-1:0]       rsp_plane,
   output logic                         rsp_stream_select,
   output logic                         rsp_bit_value,
   output logic                         rsp_last
);

   localparam int PLANE_W = $clog2(COEFF_BITS);
   localparam int PEXT_W  = (PLANE_W > PLANE_OUT_W) ? PLANE_W : PLANE_OUT_W;
   localparam logic [PLANE_W-1:0] PLANE_TOP = PLANE_W'(COEFF_BITS - 1);

   logic                  busy_ff, busy_in;
   logic [1:0]            phase_ff, phase_in;
   logic [PLANE_W-1:0]    plane_ff, plane_in;
   logic [COEFF_BITS-1:0] gray_ff, gray_in;
   logic                  sign_ff, sign_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [PLANE_OUT_W-1:0] rsp_plane_ff, rsp_plane_in;
   logic                   rsp_sel_ff, rsp_sel_in;
   logic                   rsp_bit_ff, rsp_bit_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic              advance;
   logic              fire;
   logic              done;
   logic              gray_bit;
   logic              plane_zero;
   logic              emit_sel;
   logic              emit_bit;
   logic              load;
   logic [PEXT_W-1:0] plane_ext;

   always_comb begin
      advance    = !rsp_valid_ff || !rsp_stall;
      fire       = busy_ff && advance;
      gray_bit   = gray_ff[plane_ff];
      plane_zero = (plane_ff == '0);
      plane_ext  = PEXT_W'(plane_ff);

      phase_in = phase_ff;
      plane_in = plane_ff;
      emit_sel = 1'b0;
      emit_bit = gray_bit;
      done     = 1'b0;

      case (phase_ff)
         PHASE_SIG: begin
            // stop the scan on the first set bit or at plane 0
            if (gray_bit || plane_zero) begin
               phase_in = PHASE_SIGN;
            end else begin
               plane_in = plane_ff - 1'b1;
            end
         end
         PHASE_SIGN: begin
            emit_bit = sign_ff;
            if (plane_zero) begin
               done = 1'b1;
            end else begin
               phase_in = PHASE_REF;
               plane_in = plane_ff - 1'b1;
            end
         end
         PHASE_REF: begin
            emit_sel = 1'b1;
            if (plane_zero) begin
               done = 1'b1;
            end else begin
               plane_in = plane_ff - 1'b1;
            end
         end
         default: begin
            done = 1'b1;
         end
      endcase

      if (!fire) begin
         phase_in = phase_ff;
         plane_in = plane_ff;
      end

      // take the next coefficient as soon as the current one finishes
      load    = q_status.not_empty && (!busy_ff || (fire && done));
      busy_in = busy_ff;
      gray_in = gray_ff;
      sign_in = sign_ff;
      if (load) begin
         busy_in  = 1'b1;
         phase_in = PHASE_SIG;
         plane_in = PLANE_TOP;
         gray_in  = q_pop_data[COEFF_BITS-1:0];
         sign_in  = q_pop_data[COEFF_BITS];
      end else if (fire && done) begin
         busy_in = 1'b0;
      end

      rsp_valid_in = advance ? fire : rsp_valid_ff;
      rsp_plane_in = rsp_plane_ff;
      rsp_sel_in   = rsp_sel_ff;
      rsp_bit_in   = rsp_bit_ff;
      rsp_last_in  = rsp_last_ff;
      if (fire) begin
         rsp_plane_in = plane_ext[PLANE_OUT_W-1:0];
         rsp_sel_in   = emit_sel;
         rsp_bit_in   = emit_bit;
         rsp_last_in  = done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         phase_ff     <= PHASE_SIG;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      plane_ff     <= plane_in;
      gray_ff      <= gray_in;
      sign_ff      <= sign_in;
      rsp_plane_ff <= rsp_plane_in;
      rsp_sel_ff   <= rsp_sel_in;
      rsp_bit_ff   <= rsp_bit_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign q_pop             = load;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_plane         = rsp_plane_ff;
   assign rsp_stream_select = rsp_sel_ff;
   assign rsp_bit_value     = rsp_bit_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/gray_bitplane_coeff_splitter.sv
// Top level: Gray-coded bit-plane significance/refinement splitter for signed coefficients.
`default_nettype none

// Each accepted coefficient (COEFF_BITS wide, two's complement) is Gray coded
// as an unsigned word and split into COEFF_BITS+1 result transactions, 17 at
// the default width. From the top plane down, each Gray bit goes to that
// plane's significance stream (stream_select 0) up to and including the first
// 1 or plane 0; the sign bit follows on the significance stream of the plane
// where the scan stopped; every lower plane's Gray bit then goes to its
// refinement stream (stream_select 1). The final transaction of a coefficient
// has last set and always carries plane 0. Throughput is one result per cycle
// unless rsp_stall holds the output; the back-end plane walker registers each
// result into the output stage. The front end classifies coefficients and
// pushes them into a two-entry queue; req_stall rises only while that queue is
// full, so up to two coefficients can be taken while the back end is busy or
// rsp_stall holds the output. A queued coefficient is loaded in the same cycle
// as the previous one's last result is formed, so the walker does not idle between them.
// Reset is synchronous and active high; no clearing pass is needed.
module gray_bitplane_coeff_splitter
   import gbcs_pkg::*;
#(
   parameter int COEFF_BITS = COEFF_BITS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [COEFF_BITS-1:0] req_coefficient,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [PLANE_OUT_W-1:0]     rsp_plane,
   output logic                       rsp_stream_select,
   output logic                       rsp_bit_value,
   output logic                       rsp_last
);

   gbcs_q_status_type     q_status;
   logic                  q_push;
   logic                  q_pop;
   logic [COEFF_BITS:0]   q_push_data;
   logic [COEFF_BITS:0]   q_pop_data;

   // classify and enqueue
   gbcs_front #(
      .COEFF_BITS (COEFF_BITS)
   ) u_front (
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_coefficient (req_coefficient),
      .q_status        (q_status),
      .q_push          (q_push),
      .q_push_data     (q_push_data)
   );

   // decouple front and back
   gbcs_queue #(
      .DATA_W (COEFF_BITS + 1)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .status    (q_status)
   );

   // walk the planes and emit results
   gbcs_back #(
      .COEFF_BITS (COEFF_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_status          (q_status),
      .q_pop_data        (q_pop_data),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_plane         (rsp_plane),
      .rsp_stream_select (rsp_stream_select),
      .rsp_bit_value     (rsp_bit_value),
      .rsp_last          (rsp_last)
   );

   // the final result of a coefficient always lands on plane 0
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_plane == '0)
   else $error("last result not on plane 0");

   // a plane-0 result that is not last is the scan's significance bit
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last && rsp_plane == '0 |-> !rsp_stream_select)
   else $error("refinement result on plane 0 not marked last");

   // never pop an empty queue or push a full one
   assert property (@(posedge clock) disable iff (reset)
      !(q_pop && !q_status.not_empty) && !(q_push && q_status.full))
   else $error("queue overflow or underflow");

endmodule

`default_nettype wire
